[hw/rtl/rsc_pkg.sv]
// Shared constants and types for the RPN stack calculator.
`default_nettype none
package rsc_pkg;
    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(DATA_W);
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int RESULT_DEPTH_W = 7;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH = 3'd0,
        FN_ADD  = 3'd1,
        FN_SUB  = 3'd2,
        FN_MUL  = 3'd3,
        FN_DIV  = 3'd4,
        FN_PEEK = 3'd5,
        FN_LIST = 3'd6,
        FN_NOP  = 3'd7
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_DIVZERO   = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;
endpackage
`default_nettype wire

[hw/rtl/rsc_alu.sv]
// Bit-serial add/subtract, shift-add multiply and restoring divide unit.
`default_nettype none
module rsc_alu (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire rsc_pkg::func_t             op,
    input  wire logic [rsc_pkg::DATA_W-1:0] a,
    input  wire logic [rsc_pkg::DATA_W-1:0] b,
    output logic                            done,
    output logic [rsc_pkg::DATA_W-1:0]      result
);
    import rsc_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    func_t             op_reg;
    logic [DATA_W-1:0] x_reg;
    logic [DATA_W-1:0] y_reg;
    logic [DATA_W-1:0] z_reg;
    logic [DATA_W-1:0] rem_reg;
    logic              carry_reg;
    logic              neg_reg;
    logic [DATA_W:0]   trial;
    logic              sum_bit;

    assign trial   = {rem_reg, z_reg[DATA_W-1]} - {1'b0, y_reg};
    assign sum_bit = x_reg[0] ^ y_reg[0] ^ carry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg    <= op;
            x_reg     <= a;
            carry_reg <= (op == FN_SUB);
            rem_reg   <= '0;
            neg_reg   <= a[DATA_W-1] ^ b[DATA_W-1];
            if (op == FN_DIV)
            begin
                z_reg <= a[DATA_W-1] ? (~a + 1'b1) : a;
                y_reg <= b[DATA_W-1] ? (~b + 1'b1) : b;
            end
            else
            begin
                z_reg <= '0;
                y_reg <= (op == FN_SUB) ? ~b : b;
            end
        end
        else if (busy_reg)
        begin
            case (op_reg)
                FN_MUL:
                begin
                    if (y_reg[0])
                    begin
                        z_reg <= z_reg + x_reg;
                    end
                    x_reg <= {x_reg[DATA_W-2:0], 1'b0};
                    y_reg <= {1'b0, y_reg[DATA_W-1:1]};
                end
                FN_DIV:
                begin
                    if (!trial[DATA_W])
                    begin
                        rem_reg <= trial[DATA_W-1:0];
                        z_reg   <= {z_reg[DATA_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[DATA_W-2:0], z_reg[DATA_W-1]};
                        z_reg   <= {z_reg[DATA_W-2:0], 1'b0};
                    end
                end
                default:
                begin
                    carry_reg <= (x_reg[0] & y_reg[0]) | (carry_reg & (x_reg[0] ^ y_reg[0]));
                    x_reg     <= {1'b0, x_reg[DATA_W-1:1]};
                    y_reg     <= {1'b0, y_reg[DATA_W-1:1]};
                    z_reg     <= {sum_bit, z_reg[DATA_W-1:1]};
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = (op_reg == FN_DIV && neg_reg) ? (~z_reg + 1'b1) : z_reg;
endmodule
`default_nettype wire

[hw/rtl/rpn_stack_calculator_core.sv]
// RPN stack calculator top level: stack memory, sequencer and output register.
//
//  channel | handshake         | payload
//  --------+-------------------+-------------------------------------
//  in      | in_valid/in_stall | func, value
//  out     | out_valid/out_stall | status, result_value, depth, last
//
// Push, nop, underflow and empty-stack requests go straight to emission;
// peek reads the top entry first; add, subtract, multiply and divide read
// both operands; all but divide by zero use the 32-step arithmetic unit.
// List gives one result per cycle from stack memory unless the output stalls.
// Reset clears the depth and control; stack contents are undefined until pushed.
// Output stall holds the result register and blocks the sequencer at emission.
`default_nettype none
module rpn_stack_calculator_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [rsc_pkg::FUNC_W-1:0]          func,
    input  wire logic signed [rsc_pkg::DATA_W-1:0]   value,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [rsc_pkg::STATUS_W-1:0]             status,
    output logic signed [rsc_pkg::DATA_W-1:0]        result_value,
    output logic [rsc_pkg::RESULT_DEPTH_W-1:0]       depth,
    output logic                                     last
);
    import rsc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_TOPB = 7'b0000010,
        S_TOPA = 7'b0000100,
        S_ALU  = 7'b0001000,
        S_WR   = 7'b0010000,
        S_EMIT = 7'b0100000,
        S_LIST = 7'b1000000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [DEPTH_W-1:0]  depth_reg;
    func_t               func_reg;
    logic [DATA_W-1:0]   b_reg;
    logic [DATA_W-1:0]   res_reg;
    status_t             pend_status_reg;
    logic [DATA_W-1:0]   pend_value_reg;
    logic [PTR_W-1:0]    idx_reg;

    logic [DATA_W-1:0]   mem [STACK_DEPTH];
    logic [DATA_W-1:0]   rd_data;
    logic [PTR_W-1:0]    rd_addr;
    logic                wr_en;
    logic [PTR_W-1:0]    wr_addr;
    logic [DATA_W-1:0]   wr_data;

    logic                ovalid_reg;
    status_t             ostatus_reg;
    logic [DATA_W-1:0]   ovalue_reg;
    logic [DEPTH_W-1:0]  odepth_reg;
    logic                olast_reg;

    logic                accept;
    logic                out_free;
    logic                out_load;
    logic                list_last;
    logic                alu_start;
    logic                alu_done;
    logic [DATA_W-1:0]   alu_result;
    func_t               in_func;

    assign in_func   = func_t'(func);
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !ovalid_reg || !out_stall;
    assign out_load  = out_free && (state_reg == S_EMIT || state_reg == S_LIST);
    assign list_last = ({1'b0, idx_reg} + 1'b1) == depth_reg;
    assign alu_start = (state_reg == S_TOPA) && !(func_reg == FN_DIV && b_reg == '0);

    always_comb
    begin
        rd_addr = PTR_W'(depth_reg - 1'b1);
        wr_en   = 1'b0;
        wr_addr = PTR_W'(depth_reg);
        wr_data = value;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_func == FN_LIST)
                begin
                    rd_addr = '0;
                end
                wr_en = accept && (in_func == FN_PUSH) && (depth_reg < DEPTH_W'(STACK_DEPTH));
            end
            S_TOPB: rd_addr = PTR_W'(depth_reg - 2'd2);
            S_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = PTR_W'(depth_reg - 1'b1);
                wr_data = res_reg;
            end
            S_LIST: rd_addr = out_load ? (idx_reg + 1'b1) : idx_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_func)
                        FN_ADD, FN_SUB, FN_MUL, FN_DIV:
                            state_next = (depth_reg < DEPTH_W'(2)) ? S_EMIT : S_TOPB;
                        FN_PEEK:
                            state_next = (depth_reg == '0) ? S_EMIT : S_TOPB;
                        FN_LIST:
                            state_next = (depth_reg == '0) ? S_EMIT : S_LIST;
                        default:
                            state_next = S_EMIT;
                    endcase
                end
            end
            S_TOPB: state_next = (func_reg == FN_PEEK) ? S_EMIT : S_TOPA;
            S_TOPA: state_next = alu_start ? S_ALU : S_WR;
            S_ALU:  state_next = alu_done ? S_WR : S_ALU;
            S_WR:   state_next = S_EMIT;
            S_EMIT: state_next = out_free ? S_IDLE : S_EMIT;
            S_LIST: state_next = (out_free && list_last) ? S_IDLE : S_LIST;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            depth_reg  <= '0;
            ovalid_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en && state_reg == S_IDLE)
            begin
                depth_reg <= depth_reg + 1'b1;
            end
            else if (state_reg == S_TOPA)
            begin
                depth_reg <= depth_reg - 1'b1;
            end
            if (accept)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == S_LIST && out_load)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (out_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg       <= in_func;
            pend_value_reg <= '0;
            unique case (in_func)
                FN_ADD, FN_SUB, FN_MUL, FN_DIV:
                    pend_status_reg <= (depth_reg < DEPTH_W'(2)) ? ST_UNDERFLOW : ST_OK;
                FN_PEEK, FN_LIST:
                    pend_status_reg <= (depth_reg == '0) ? ST_EMPTY : ST_OK;
                default:
                    pend_status_reg <= ST_OK;
            endcase
        end
        if (state_reg == S_TOPB)
        begin
            b_reg <= rd_data;
            if (func_reg == FN_PEEK)
            begin
                pend_value_reg <= rd_data;
            end
        end
        if (state_reg == S_TOPA && !alu_start)
        begin
            res_reg         <= rd_data;
            pend_status_reg <= ST_DIVZERO;
        end
        if (state_reg == S_ALU && alu_done)
        begin
            res_reg <= alu_result;
        end
        if (out_load)
        begin
            odepth_reg <= depth_reg;
            if (state_reg == S_LIST)
            begin
                ostatus_reg <= ST_OK;
                ovalue_reg  <= rd_data;
                olast_reg   <= list_last;
            end
            else
            begin
                ostatus_reg <= pend_status_reg;
                ovalue_reg  <= pend_value_reg;
                olast_reg   <= 1'b1;
            end
        end
    end

    rsc_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (alu_start),
        .op     (func_reg),
        .a      (rd_data),
        .b      (b_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    assign out_valid    = ovalid_reg;
    assign status       = ostatus_reg;
    assign result_value = ovalue_reg;
    assign depth        = RESULT_DEPTH_W'(odepth_reg);
    assign last         = olast_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_alu_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> (state_reg == S_ALU))
        else $error("arithmetic unit finished outside its state");

    a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |-> (depth_reg != '0))
        else $error("list walk on empty stack");
endmodule
`default_nettype wire
